>>> sv/bt_pkg.sv
// shared types and constants for the breakpoint table
`timescale 1ns / 1ps

package bt_pkg;

  localparam int unsigned SPACE_W = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned IDX_W   = 7;

  localparam logic [SPACE_W-1:0] KERNEL_RST = 16'd1;

  // command codes
  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_FIND = 2'd2
  } cmd_e;

  // status codes
  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_ALREADY = 2'd1,
    STS_FULL    = 2'd2,
    STS_NOTSET  = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_POP,
    S_ALLOC,
    S_FREE,
    S_RESP
  } state_e;

  // one row of the entry memory
  typedef struct packed {
    logic               valid;
    logic [SPACE_W-1:0] space;
    logic [ADDR_W-1:0]  addr;
    logic [COUNT_W-1:0] count;
  } entry_t;

  // lookup key of the current command
  typedef struct packed {
    logic [SPACE_W-1:0] space;
    logic [ADDR_W-1:0]  addr;
  } key_t;

  // result beat handed from the sequencer to the output register
  typedef struct packed {
    logic               valid;
    status_e            status;
    logic               hit;
    logic [IDX_W-1:0]   idx;
    logic [COUNT_W-1:0] count;
  } resp_t;

endpackage

>>> sv/bt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module bt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/bt_match.sv
// key compare unit shared by every scan step
`timescale 1ns / 1ps

module bt_match (
  input  bt_pkg::entry_t               ent_i,
  input  bt_pkg::key_t                 key_i,
  input  logic [bt_pkg::SPACE_W-1:0]   kernel_i,
  output logic                         match_o
);

  logic space_eq;
  logic addr_eq;

  // space zero stands for the kernel space, in either direction
  always_comb begin
    space_eq = (ent_i.space == key_i.space)
            || ((ent_i.space == '0) && (key_i.space == kernel_i))
            || ((ent_i.space == kernel_i) && (key_i.space == '0));
    addr_eq  = (ent_i.addr == key_i.addr);
  end

  assign match_o = ent_i.valid && addr_eq && space_eq;

endmodule

>>> sv/bt_ctrl.sv
// command sequencer: clear pass, linear scan, slot allocation and release
`timescale 1ns / 1ps

module bt_ctrl #(
  parameter int unsigned ENTRIES = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command beat
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    cmd_i,
  input  logic [bt_pkg::SPACE_W-1:0]    space_id_i,
  input  logic [bt_pkg::ADDR_W-1:0]     address_i,
  input  logic [bt_pkg::COUNT_W-1:0]    skip_count_i,
  // compare unit
  output bt_pkg::key_t                  key_o,
  input  logic                          match_i,
  // entry memory
  output logic                          ent_we_o,
  output logic [$clog2(ENTRIES)-1:0]    ent_waddr_o,
  output bt_pkg::entry_t                ent_wdata_o,
  output logic [$clog2(ENTRIES)-1:0]    ent_raddr_o,
  input  bt_pkg::entry_t                ent_rdata_i,
  // free slot stack
  output logic                          fs_we_o,
  output logic [$clog2(ENTRIES)-1:0]    fs_waddr_o,
  output logic [$clog2(ENTRIES)-1:0]    fs_wdata_o,
  output logic [$clog2(ENTRIES)-1:0]    fs_raddr_o,
  input  logic [$clog2(ENTRIES)-1:0]    fs_rdata_i,
  // result beat
  output bt_pkg::resp_t                 resp_o,
  input  logic                          resp_take_i
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned PW = (AW > bt_pkg::IDX_W) ? AW : bt_pkg::IDX_W;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  bt_pkg::state_e state_q, state_d;

  logic [AW-1:0]               scan_q, scan_d;
  logic                        issue_q, issue_d;
  logic                        rdv_q, rdv_d;
  logic [AW-1:0]               rdi_q, rdi_d;
  logic [1:0]                  cmd_q, cmd_d;
  bt_pkg::key_t                key_q, key_d;
  logic [bt_pkg::COUNT_W-1:0]  cnt_q, cnt_d;
  logic                        found_q, found_d;
  logic                        full_q, full_d;
  logic                        pop_q, pop_d;
  logic [AW-1:0]               slot_q, slot_d;
  logic [bt_pkg::COUNT_W-1:0]  fcnt_q, fcnt_d;
  logic [CW-1:0]               free_top_q, free_top_d;
  logic [CW-1:0]               fresh_q, fresh_d;

  logic                        hit_now;
  logic                        last_now;
  logic                        stack_empty;
  logic                        fresh_left;
  logic [AW-1:0]               alloc_slot;
  logic [CW-1:0]               top_dec;
  logic [PW-1:0]               slot_wide;
  logic                        cmd_known;

  // scan step outcome and allocation helpers
  always_comb begin
    hit_now     = rdv_q && match_i;
    last_now    = rdv_q && (rdi_q == LAST);
    stack_empty = (free_top_q == '0);
    fresh_left  = (fresh_q < FULL_CNT);
    alloc_slot  = pop_q ? fs_rdata_i : fresh_q[AW-1:0];
    top_dec     = free_top_q - CW'(1);
    slot_wide   = PW'(slot_q);
    cmd_known   = (cmd_q == bt_pkg::CMD_SET) || (cmd_q == bt_pkg::CMD_DEL)
               || (cmd_q == bt_pkg::CMD_FIND);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bt_pkg::S_CLEAR: begin
        if (scan_q == LAST) state_d = bt_pkg::S_IDLE;
      end
      bt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if ((cmd_i == bt_pkg::CMD_SET) || (cmd_i == bt_pkg::CMD_DEL)
              || (cmd_i == bt_pkg::CMD_FIND)) begin
            state_d = bt_pkg::S_SCAN;
          end else begin
            state_d = bt_pkg::S_RESP;
          end
        end
      end
      bt_pkg::S_SCAN: begin
        if (hit_now) begin
          state_d = (cmd_q == bt_pkg::CMD_DEL) ? bt_pkg::S_FREE : bt_pkg::S_RESP;
        end else if (last_now) begin
          if (cmd_q == bt_pkg::CMD_SET) begin
            if (!stack_empty)    state_d = bt_pkg::S_POP;
            else if (fresh_left) state_d = bt_pkg::S_ALLOC;
            else                 state_d = bt_pkg::S_RESP;
          end else begin
            state_d = bt_pkg::S_RESP;
          end
        end
      end
      bt_pkg::S_POP:   state_d = bt_pkg::S_ALLOC;
      bt_pkg::S_ALLOC: state_d = bt_pkg::S_RESP;
      bt_pkg::S_FREE:  state_d = bt_pkg::S_RESP;
      bt_pkg::S_RESP: begin
        if (resp_take_i) state_d = bt_pkg::S_IDLE;
      end
      default: state_d = bt_pkg::S_CLEAR;
    endcase
  end

  // datapath register updates
  always_comb begin
    scan_d     = scan_q;
    issue_d    = issue_q;
    rdv_d      = rdv_q;
    rdi_d      = rdi_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    found_d    = found_q;
    full_d     = full_q;
    pop_d      = pop_q;
    slot_d     = slot_q;
    fcnt_d     = fcnt_q;
    free_top_d = free_top_q;
    fresh_d    = fresh_q;
    unique case (state_q)
      bt_pkg::S_CLEAR: begin
        scan_d = scan_q + AW'(1);
      end
      bt_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_d       = cmd_i;
          key_d.space = space_id_i;
          key_d.addr  = address_i;
          cnt_d       = skip_count_i;
          scan_d      = '0;
          issue_d     = 1'b1;
          rdv_d       = 1'b0;
          found_d     = 1'b0;
          full_d      = 1'b0;
          pop_d       = 1'b0;
          slot_d      = '0;
          fcnt_d      = '0;
        end
      end
      bt_pkg::S_SCAN: begin
        // issue one read per cycle, compare one row per cycle
        rdv_d = issue_q;
        rdi_d = scan_q;
        if (issue_q) begin
          if (scan_q == LAST) issue_d = 1'b0;
          else                scan_d  = scan_q + AW'(1);
        end
        if (hit_now) begin
          found_d = 1'b1;
          slot_d  = rdi_q;
          fcnt_d  = ent_rdata_i.count;
          issue_d = 1'b0;
        end else if (last_now) begin
          issue_d = 1'b0;
          if ((cmd_q == bt_pkg::CMD_SET) && stack_empty && !fresh_left) full_d = 1'b1;
        end
      end
      bt_pkg::S_POP: begin
        free_top_d = top_dec;
        pop_d      = 1'b1;
      end
      bt_pkg::S_ALLOC: begin
        slot_d = alloc_slot;
        if (!pop_q) fresh_d = fresh_q + CW'(1);
      end
      bt_pkg::S_FREE: begin
        if (free_top_q < FULL_CNT) free_top_d = free_top_q + CW'(1);
      end
      bt_pkg::S_RESP: begin
        rdv_d = 1'b0;
      end
      default: begin
        rdv_d = 1'b0;
      end
    endcase
  end

  // memory controls and result
  always_comb begin
    in_stall_o  = (state_q != bt_pkg::S_IDLE);
    key_o       = key_q;
    ent_raddr_o = scan_q;
    ent_we_o    = 1'b0;
    ent_waddr_o = scan_q;
    ent_wdata_o = '0;
    fs_raddr_o  = top_dec[AW-1:0];
    fs_we_o     = 1'b0;
    fs_waddr_o  = free_top_q[AW-1:0];
    fs_wdata_o  = slot_q;
    resp_o      = '0;
    unique case (state_q)
      bt_pkg::S_CLEAR: begin
        ent_we_o = 1'b1;
      end
      bt_pkg::S_ALLOC: begin
        ent_we_o          = 1'b1;
        ent_waddr_o       = alloc_slot;
        ent_wdata_o.valid = 1'b1;
        ent_wdata_o.space = key_q.space;
        ent_wdata_o.addr  = key_q.addr;
        ent_wdata_o.count = cnt_q;
      end
      bt_pkg::S_FREE: begin
        ent_we_o    = 1'b1;
        ent_waddr_o = slot_q;
        fs_we_o     = (free_top_q < FULL_CNT);
      end
      bt_pkg::S_RESP: begin
        resp_o.valid = 1'b1;
        if (cmd_known) begin
          resp_o.hit = found_q;
          if (found_q) begin
            resp_o.status = (cmd_q == bt_pkg::CMD_SET) ? bt_pkg::STS_ALREADY
                                                       : bt_pkg::STS_OK;
            resp_o.idx    = slot_wide[bt_pkg::IDX_W-1:0];
            resp_o.count  = (cmd_q == bt_pkg::CMD_DEL) ? '0 : fcnt_q;
          end else if (cmd_q == bt_pkg::CMD_SET) begin
            resp_o.status = full_q ? bt_pkg::STS_FULL : bt_pkg::STS_OK;
            resp_o.idx    = full_q ? '0 : slot_wide[bt_pkg::IDX_W-1:0];
          end else begin
            resp_o.status = bt_pkg::STS_NOTSET;
          end
        end
      end
      default: begin
        resp_o = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= bt_pkg::S_CLEAR;
      scan_q     <= '0;
      issue_q    <= 1'b0;
      rdv_q      <= 1'b0;
      found_q    <= 1'b0;
      full_q     <= 1'b0;
      pop_q      <= 1'b0;
      free_top_q <= '0;
      fresh_q    <= '0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      issue_q    <= issue_d;
      rdv_q      <= rdv_d;
      found_q    <= found_d;
      full_q     <= full_d;
      pop_q      <= pop_d;
      free_top_q <= free_top_d;
      fresh_q    <= fresh_d;
    end
  end

  // command payload registers
  always_ff @(posedge clk_i) begin
    rdi_q  <= rdi_d;
    cmd_q  <= cmd_d;
    key_q  <= key_d;
    cnt_q  <= cnt_d;
    slot_q <= slot_d;
    fcnt_q <= fcnt_d;
  end

endmodule

>>> sv/breakpoint_table_top.sv
// breakpoint table top level: kernel space register, memories, sequencer, result register
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | cmd_i space_id_i address_i skip_count_i
//  out     | output    | out_valid_o / out_stall_i | status_o hit_o entry_index_o entry_count_o
//  cfg     | input     | cfg_wr_en_i               | cfg_wr_data_i (kernel space)
//
// a miss scans every row before the result; a set that misses then takes a freed slot off
// the stack if there is one, else a fresh slot; a match at slot i ends the scan early, and
// a delete then releases that slot.
// the scan reads one entry memory row per cycle through a single key comparator.
// an unused command code answers without a scan.
// after reset a clearing pass marks every slot unused; in_stall_o is
// high meanwhile, configuration writes are taken as always.
// a finished result waits in the output register; the next command is taken meanwhile
// and its result waits in the sequencer until the output register frees up.
`timescale 1ns / 1ps

module breakpoint_table_top #(
  parameter int unsigned ENTRIES = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_wr_en_i,
  input  logic [bt_pkg::SPACE_W-1:0] cfg_wr_data_i,
  // command channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 cmd_i,
  input  logic [bt_pkg::SPACE_W-1:0] space_id_i,
  input  logic [bt_pkg::ADDR_W-1:0]  address_i,
  input  logic [bt_pkg::COUNT_W-1:0] skip_count_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic                       hit_o,
  output logic [bt_pkg::IDX_W-1:0]   entry_index_o,
  output logic [bt_pkg::COUNT_W-1:0] entry_count_o
);

  localparam int unsigned AW = $clog2(ENTRIES);

  logic [bt_pkg::SPACE_W-1:0] kernel_q;

  bt_pkg::key_t   key;
  logic           match;
  logic           ent_we;
  logic [AW-1:0]  ent_waddr;
  logic [AW-1:0]  ent_raddr;
  bt_pkg::entry_t ent_wdata;
  bt_pkg::entry_t ent_rdata;
  logic           fs_we;
  logic [AW-1:0]  fs_waddr;
  logic [AW-1:0]  fs_wdata;
  logic [AW-1:0]  fs_raddr;
  logic [AW-1:0]  fs_rdata;
  bt_pkg::resp_t  resp;
  logic           resp_take;

  logic                       out_valid_q;
  bt_pkg::status_e            status_q;
  logic                       hit_q;
  logic [bt_pkg::IDX_W-1:0]   idx_q;
  logic [bt_pkg::COUNT_W-1:0] count_q;

  // kernel space register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_q <= bt_pkg::KERNEL_RST;
    end else if (cfg_wr_en_i) begin
      kernel_q <= cfg_wr_data_i;
    end
  end

  // entry rows: valid, space, address, skip count
  bt_ram #(
    .WIDTH ($bits(bt_pkg::entry_t)),
    .DEPTH (ENTRIES)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // stack of freed slots
  bt_ram #(
    .WIDTH (AW),
    .DEPTH (ENTRIES)
  ) u_fs_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  bt_match u_match (
    .ent_i    (ent_rdata),
    .key_i    (key),
    .kernel_i (kernel_q),
    .match_o  (match)
  );

  bt_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .space_id_i   (space_id_i),
    .address_i    (address_i),
    .skip_count_i (skip_count_i),
    .key_o        (key),
    .match_i      (match),
    .ent_we_o     (ent_we),
    .ent_waddr_o  (ent_waddr),
    .ent_wdata_o  (ent_wdata),
    .ent_raddr_o  (ent_raddr),
    .ent_rdata_i  (ent_rdata),
    .fs_we_o      (fs_we),
    .fs_waddr_o   (fs_waddr),
    .fs_wdata_o   (fs_wdata),
    .fs_raddr_o   (fs_raddr),
    .fs_rdata_i   (fs_rdata),
    .resp_o       (resp),
    .resp_take_i  (resp_take)
  );

  // output register takes a result when empty or draining
  assign resp_take = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp.valid && resp_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp.valid && resp_take) begin
      status_q <= resp.status;
      hit_q    <= resp.hit;
      idx_q    <= resp.idx;
      count_q  <= resp.count;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign hit_o         = hit_q;
  assign entry_index_o = idx_q;
  assign entry_count_o = count_q;

endmodule

>>> sv/bt_chk.sv
// port-level checks for the breakpoint table, bound to the top level
`timescale 1ns / 1ps

module bt_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [1:0]                 cmd_i,
  input logic [bt_pkg::SPACE_W-1:0] space_id_i,
  input logic [bt_pkg::ADDR_W-1:0]  address_i,
  input logic [bt_pkg::COUNT_W-1:0] skip_count_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 status_o,
  input logic                       hit_o,
  input logic [bt_pkg::IDX_W-1:0]   entry_index_o,
  input logic [bt_pkg::COUNT_W-1:0] entry_count_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(hit_o)
      && $stable(entry_index_o) && $stable(entry_count_o))
    else $error("stalled result beat changed");

  // a stalled command beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(cmd_i) && $stable(space_id_i)
      && $stable(address_i) && $stable(skip_count_i))
    else $error("stalled command beat changed");

  // one command at a time: the block is busy right after taking a beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("command accepted while previous one still in work");

  // a count is reported only with a hit
  a_count_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> entry_count_o == '0)
    else $error("nonzero count without hit");

  // status agrees with hit and index
  a_status_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == bt_pkg::STS_ALREADY) ? hit_o : 1'b1)
      && (((status_o == bt_pkg::STS_FULL) || (status_o == bt_pkg::STS_NOTSET))
          ? (!hit_o && entry_index_o == '0) : 1'b1))
    else $error("status inconsistent with hit or index");

endmodule

bind breakpoint_table_top bt_chk u_bt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .cmd_i         (cmd_i),
  .space_id_i    (space_id_i),
  .address_i     (address_i),
  .skip_count_i  (skip_count_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .status_o      (status_o),
  .hit_o         (hit_o),
  .entry_index_o (entry_index_o),
  .entry_count_o (entry_count_o)
);
